@@ sv/svd_pkg.sv @@
// ============================================================================
// svd_pkg
// Shared types, constants and helpers for the soft-decision Viterbi decoder.
// ============================================================================
package svd_pkg;

	localparam int CONSTRAINT_LEN = 7;
	localparam int NODE_W         = CONSTRAINT_LEN;
	localparam int NODES          = 1 << NODE_W;
	localparam int METRIC_W       = 16;
	localparam int SOFT_W         = 8;
	localparam int COST_W         = 8;
	localparam int BCOST_W        = COST_W + 1;
	localparam int POLY_W         = 7;
	localparam int BYTE_W         = 8;
	localparam int CFG_IDX_W      = 2;

	localparam int DEF_WINDOW_DEPTH = 96;
	localparam int DEF_TRACE_DEPTH  = 32;

	localparam logic [POLY_W-1:0]   POLY_FIRST_RST  = 7'h4F;
	localparam logic [POLY_W-1:0]   POLY_SECOND_RST = 7'h6D;
	localparam logic [METRIC_W-1:0] CEILING_RST     = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY_FIRST     = 2'd0,
		REG_POLY_SECOND    = 2'd1,
		REG_METRIC_CEILING = 2'd2
	} cfg_reg_t;

	// Result of one add-compare-select sweep.
	typedef struct packed {
		logic                done;
		logic [NODE_W-1:0]   best_node;
		logic [METRIC_W-1:0] best_metric;
	} acs_result_t;

	// Command to the traceback engine.
	typedef struct packed {
		logic              start;
		logic              window;
		logic              last;
		logic [NODE_W-1:0] node;
	} trace_cmd_t;

	// Cost of one soft value against an expected code bit. The most negative
	// code carries no information and costs nothing.
	function automatic logic [COST_W-1:0] soft_cost(input logic signed [SOFT_W-1:0] s,
			input logic expect_one);
		logic signed [SOFT_W+1:0] t;
		t = expect_one ? (10'sd128 - 10'(s)) : (10'sd128 + 10'(s));
		if (s == -8'sd128)
			return '0;
		return t[COST_W-1:0];
	endfunction

endpackage

@@ sv/svd_pm_ram.sv @@
// ============================================================================
// svd_pm_ram
// Path metric bank: one write port, two registered read ports.
// ============================================================================
module svd_pm_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [svd_pkg::NODE_W-1:0]    waddr,
	input  logic [svd_pkg::METRIC_W-1:0]  wdata,
	input  logic [svd_pkg::NODE_W-1:0]    raddr0,
	input  logic [svd_pkg::NODE_W-1:0]    raddr1,
	output logic [svd_pkg::METRIC_W-1:0]  rdata0,
	output logic [svd_pkg::METRIC_W-1:0]  rdata1
);
	import svd_pkg::*;

	logic [METRIC_W-1:0] mem_q [NODES];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

@@ sv/svd_acs.sv @@
// ============================================================================
// svd_acs
// Shared add-compare-select unit, one trellis node per cycle, ping-pong banks.
// ============================================================================
module svd_acs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [svd_pkg::SOFT_W-1:0]   soft_first,
	input  logic signed [svd_pkg::SOFT_W-1:0]   soft_second,
	input  logic [svd_pkg::POLY_W-1:0]          poly_first,
	input  logic [svd_pkg::POLY_W-1:0]          poly_second,
	input  logic [svd_pkg::METRIC_W-1:0]        ceiling,
	input  logic [svd_pkg::METRIC_W-1:0]        sub,
	input  logic                                zero,
	input  logic                                bank,
	output svd_pkg::acs_result_t                res,
	output logic [svd_pkg::NODES-1:0]           dec_row
);
	import svd_pkg::*;

	logic [BCOST_W-1:0]  bc_q [4];
	logic                run_q;
	logic [NODE_W-1:0]   n_q;
	logic                v_s1, v_s2;
	logic [NODE_W-1:0]   node_s1, node_s2;
	logic [METRIC_W-1:0] m_s2;
	logic                dec_s2;
	logic [BCOST_W-1:0]  bc_s2;
	logic                done_q;
	logic [NODE_W-1:0]   best_node_q;
	logic [METRIC_W-1:0] best_q;
	logic [NODES-1:0]    row_q;

	logic [NODE_W-1:0]   ra0, ra1;
	logic [METRIC_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
	logic [METRIC_W-1:0] m0, m1;
	logic [1:0]          code;
	logic [METRIC_W:0]   sum;
	logic [METRIC_W-1:0] sat;
	logic                we_a, we_b;

	assign ra0  = {n_q[NODE_W-2:0], 1'b0};
	assign ra1  = {n_q[NODE_W-2:0], 1'b1};
	assign we_a = v_s2 && bank;
	assign we_b = v_s2 && !bank;

	svd_pm_ram u_bank_a (
		.clk(clk), .we(we_a), .waddr(node_s2), .wdata(sat),
		.raddr0(ra0), .raddr1(ra1), .rdata0(rd_a0), .rdata1(rd_a1)
	);

	svd_pm_ram u_bank_b (
		.clk(clk), .we(we_b), .waddr(node_s2), .wdata(sat),
		.raddr0(ra0), .raddr1(ra1), .rdata0(rd_b0), .rdata1(rd_b1)
	);

	// Pending normalization is applied on the read side; a flushed trellis
	// reads as all zero.
	always_comb begin
		m0   = zero ? '0 : ((bank ? rd_b0 : rd_a0) - sub);
		m1   = zero ? '0 : ((bank ? rd_b1 : rd_a1) - sub);
		code = {^(node_s1 & poly_first), ^(node_s1 & poly_second)};
		sum  = {1'b0, m_s2} + (METRIC_W+1)'(bc_s2);
		sat  = (sum > {1'b0, ceiling}) ? ceiling : sum[METRIC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			n_q    <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				n_q   <= '0;
			end else if (run_q) begin
				n_q <= n_q + 1'b1;
				if (n_q == NODE_W'(NODES-1))
					run_q <= 1'b0;
			end
			v_s1   <= run_q;
			v_s2   <= v_s1;
			done_q <= v_s2 && (node_s2 == NODE_W'(NODES-1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int c = 0; c < 4; c++)
				bc_q[c] <= BCOST_W'(soft_cost(soft_first, c[1]))
					+ BCOST_W'(soft_cost(soft_second, c[0]));
		end
		node_s1 <= n_q;
		node_s2 <= node_s1;
		m_s2    <= (m0 < m1) ? m0 : m1;
		dec_s2  <= !(m0 < m1);
		bc_s2   <= bc_q[code];
		if (v_s2) begin
			row_q[node_s2] <= dec_s2;
			if ((node_s2 == '0) || (sat < best_q)) begin
				best_q      <= sat;
				best_node_q <= node_s2;
			end
		end
	end

	assign res.done        = done_q;
	assign res.best_node   = best_node_q;
	assign res.best_metric = best_q;
	assign dec_row         = row_q;

endmodule

@@ sv/svd_trace.sv @@
// ============================================================================
// svd_trace
// Survivor memory, traceback walker, byte reorder buffer and output register.
// ============================================================================
module svd_trace #(
	parameter int WINDOW_DEPTH = svd_pkg::DEF_WINDOW_DEPTH,
	parameter int TRACE_DEPTH  = svd_pkg::DEF_TRACE_DEPTH,
	parameter int LW = $clog2(WINDOW_DEPTH),
	parameter int FW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          row_we,
	input  logic [LW-1:0]                 row_layer,
	input  logic [svd_pkg::NODES-1:0]     row_data,
	input  svd_pkg::trace_cmd_t           cmd,
	input  logic [FW-1:0]                 fill,
	input  logic [LW-1:0]                 base,
	output logic                          done,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [svd_pkg::BYTE_W-1:0]    out_data,
	output logic                          out_last
);
	import svd_pkg::*;

	localparam int NB     = WINDOW_DEPTH / 8;
	localparam int NBW    = $clog2(NB + 1);
	localparam int IW     = (NB > 1) ? $clog2(NB) : 1;
	localparam int SKW    = $clog2(TRACE_DEPTH + 1);
	localparam int WIN_NB = (WINDOW_DEPTH - TRACE_DEPTH) / 8;

	typedef enum logic [2:0] {T_IDLE, T_RD, T_USE, T_ORD, T_OPUT} tstate_t;

	logic [NODES-1:0]  surv_q [WINDOW_DEPTH];
	logic [BYTE_W-1:0] buf_q [NB];

	tstate_t           state_q;
	logic [NODE_W-1:0] node_q;
	logic [LW-1:0]     layer_q;
	logic [SKW-1:0]    skip_q;
	logic [NBW-1:0]    nbytes_q;
	logic [IW-1:0]     widx_q, ridx_q;
	logic [2:0]        bit_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q, done_q;
	logic [NODES-1:0]  row_rd_q;
	logic [BYTE_W-1:0] buf_rd_q;
	logic              out_valid_q, out_last_q;
	logic [BYTE_W-1:0] out_data_q;

	logic [LW:0]       psum;
	logic [LW-1:0]     rd_phys;
	logic              sel_bit;
	logic [BYTE_W-1:0] byte_next;
	logic [NBW-1:0]    nb_start;
	logic              out_free;
	logic              buf_we;

	always_comb begin
		psum = (LW+1)'(base) + (LW+1)'(layer_q);
		if (psum >= (LW+1)'(WINDOW_DEPTH))
			psum = psum - (LW+1)'(WINDOW_DEPTH);
		rd_phys   = psum[LW-1:0];
		sel_bit   = row_rd_q[node_q];
		byte_next = {node_q[NODE_W-1], byte_q[BYTE_W-1:1]};
		nb_start  = cmd.window ? NBW'(WIN_NB) : NBW'(fill >> 3);
		out_free  = !out_valid_q || out_ready;
		buf_we    = (state_q == T_USE) && (skip_q == '0) && (bit_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (row_we)
			surv_q[row_layer] <= row_data;
		row_rd_q <= surv_q[rd_phys];
	end

	always_ff @(posedge clk) begin
		if (buf_we)
			buf_q[widx_q] <= byte_next;
		buf_rd_q <= buf_q[ridx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (cmd.start) begin
						if (nb_start == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= T_RD;
						end
					end
				end
				T_RD: state_q <= T_USE;
				T_USE: begin
					if (skip_q != '0) begin
						state_q <= T_RD;
					end else if (bit_q == 3'd7 && widx_q == '0) begin
						state_q <= T_ORD;
					end else begin
						state_q <= T_RD;
					end
				end
				T_ORD: state_q <= T_OPUT;
				T_OPUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (NBW'(ridx_q) == nbytes_q - 1'b1) begin
							state_q <= T_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= T_ORD;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// Walker payload.
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				node_q   <= cmd.node;
				last_q   <= cmd.last;
				nbytes_q <= nb_start;
				widx_q   <= IW'(nb_start - 1'b1);
				ridx_q   <= '0;
				bit_q    <= '0;
				if (cmd.window) begin
					layer_q <= LW'(WINDOW_DEPTH - 1);
					skip_q  <= SKW'(TRACE_DEPTH);
				end else begin
					layer_q <= LW'(fill - 1'b1);
					skip_q  <= SKW'(fill[2:0]);
				end
			end
			T_USE: begin
				node_q  <= {node_q[NODE_W-2:0], sel_bit};
				layer_q <= layer_q - 1'b1;
				if (skip_q != '0) begin
					skip_q <= skip_q - 1'b1;
				end else begin
					byte_q <= byte_next;
					bit_q  <= bit_q + 1'b1;
					if (bit_q == 3'd7)
						widx_q <= widx_q - 1'b1;
				end
			end
			T_OPUT: begin
				if (out_free) begin
					out_data_q <= buf_rd_q;
					out_last_q <= last_q && (NBW'(ridx_q) == nbytes_q - 1'b1);
					ridx_q     <= ridx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

@@ sv/soft_viterbi_decoder_k7_rate_half_unit.sv @@
// ============================================================================
// soft_viterbi_decoder_k7_rate_half_unit
// Soft-decision Viterbi decoder, rate 1/2, constraint 7, windowed traceback.
// ============================================================================
// Usage:
// The slave stream takes one symbol pair per beat: s_tdata holds the two
// signed soft values and s_tlast asks for a flush after that symbol. The
// master stream delivers decoded bytes, oldest bit in the MSB, with m_tlast
// set on the last byte caused by one input beat. Most beats produce no byte.
// Each symbol runs one add-compare-select sweep over all 128 nodes through a
// single shared unit, during which s_tready is low. When the survivor
// window fills, a traceback walks the window, reading and using each layer
// and then reordering and sending each byte; at the default depths this
// comes once every 64 symbols after the first window. A flush walks every
// held layer the same way and sends the whole bytes among them.
// If the receiver stalls, the walker waits on the output register and the
// slave side stays busy until the last byte is loaded there; the next symbol
// may be accepted while that byte still waits to be taken.
// Reset clears the metrics, the window and the registers to their defaults.
// The survivor memory needs no clearing pass. The configuration channel is
// always ready; the user must write it only while the decoder is idle.
// The block does not enforce it. TRACE_DEPTH must not exceed WINDOW_DEPTH.
module soft_viterbi_decoder_k7_rate_half_unit #(
	parameter int WINDOW_DEPTH = svd_pkg::DEF_WINDOW_DEPTH,
	parameter int TRACE_DEPTH  = svd_pkg::DEF_TRACE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // soft_first, soft_second
	input  logic                             s_tlast,   // end_of_stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // data_byte
	output logic                             m_tlast,   // last_of_run
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [svd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data
);
	import svd_pkg::*;

	localparam int LW  = $clog2(WINDOW_DEPTH);
	localparam int FW  = $clog2(WINDOW_DEPTH + 1);
	localparam int ADV = WINDOW_DEPTH - TRACE_DEPTH;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACS, ST_WIN, ST_WIN_WAIT, ST_FLUSH, ST_FLUSH_WAIT
	} state_t;

	state_t              state_q;
	logic [POLY_W-1:0]   poly_first_q, poly_second_q;
	logic [METRIC_W-1:0] ceiling_q;
	logic [METRIC_W-1:0] sub_q;
	logic                zero_q, bank_q, eos_q;
	logic [FW-1:0]       fill_q;
	logic [LW-1:0]       base_q;

	logic                accept;
	acs_result_t         acs_res;
	logic [NODES-1:0]    dec_row;
	trace_cmd_t          tcmd;
	logic                trace_done;
	logic [LW:0]         wsum, bsum;
	logic [LW-1:0]       wr_phys;
	logic                full;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Physical row of the layer being written, and the base after a window
	// trace; the survivor window is a ring so kept layers never move.
	always_comb begin
		wsum = (LW+1)'(base_q) + (LW+1)'(fill_q);
		if (wsum >= (LW+1)'(WINDOW_DEPTH))
			wsum = wsum - (LW+1)'(WINDOW_DEPTH);
		wr_phys = wsum[LW-1:0];
		bsum = (LW+1)'(base_q) + (LW+1)'(ADV);
		if (bsum >= (LW+1)'(WINDOW_DEPTH))
			bsum = bsum - (LW+1)'(WINDOW_DEPTH);
		full = (fill_q == FW'(WINDOW_DEPTH - 1));
	end

	always_comb begin
		tcmd.node   = acs_res.best_node;
		tcmd.window = (state_q == ST_WIN);
		tcmd.last   = (state_q == ST_WIN) ? !eos_q : 1'b1;
		tcmd.start  = (state_q == ST_WIN) || (state_q == ST_FLUSH);
	end

	svd_acs u_acs (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.soft_first(s_tdata[7:0]), .soft_second(s_tdata[15:8]),
		.poly_first(poly_first_q), .poly_second(poly_second_q),
		.ceiling(ceiling_q), .sub(sub_q), .zero(zero_q), .bank(bank_q),
		.res(acs_res), .dec_row(dec_row)
	);

	svd_trace #(
		.WINDOW_DEPTH(WINDOW_DEPTH), .TRACE_DEPTH(TRACE_DEPTH), .LW(LW), .FW(FW)
	) u_trace (
		.clk(clk), .arst_n(arst_n),
		.row_we((state_q == ST_ACS) && acs_res.done), .row_layer(wr_phys),
		.row_data(dec_row), .cmd(tcmd), .fill(fill_q), .base(base_q),
		.done(trace_done),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.out_last(m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			poly_first_q  <= POLY_FIRST_RST;
			poly_second_q <= POLY_SECOND_RST;
			ceiling_q     <= CEILING_RST;
			sub_q         <= '0;
			zero_q        <= 1'b1;
			bank_q        <= 1'b0;
			eos_q         <= 1'b0;
			fill_q        <= '0;
			base_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_POLY_FIRST:     poly_first_q  <= cfg_data[POLY_W-1:0];
					REG_POLY_SECOND:    poly_second_q <= cfg_data[POLY_W-1:0];
					REG_METRIC_CEILING: ceiling_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eos_q   <= s_tlast;
						state_q <= ST_ACS;
						if (fill_q >= FW'(WINDOW_DEPTH))
							fill_q <= '0;
					end
				end
				ST_ACS: begin
					if (acs_res.done) begin
						fill_q <= fill_q + 1'b1;
						zero_q <= 1'b0;
						bank_q <= !bank_q;
						sub_q  <= full ? acs_res.best_metric : '0;
						if (full)
							state_q <= ST_WIN;
						else if (eos_q)
							state_q <= ST_FLUSH;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_WIN: state_q <= ST_WIN_WAIT;
				ST_WIN_WAIT: begin
					if (trace_done) begin
						base_q  <= bsum[LW-1:0];
						fill_q  <= FW'(TRACE_DEPTH);
						state_q <= eos_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// The walker takes the held depth at this edge.
					fill_q  <= '0;
					zero_q  <= 1'b1;
					state_q <= ST_FLUSH_WAIT;
				end
				ST_FLUSH_WAIT: begin
					if (trace_done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/svd_checker.sv @@
// ============================================================================
// svd_checker
// Port-level checks for the Viterbi decoder, bound to the top level.
// ============================================================================
module svd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Each accepted symbol drops s_tready as its node sweep begins.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input accepted during a node sweep");

	// Configuration writes are never refused.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind soft_viterbi_decoder_k7_rate_half_unit svd_checker u_svd_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

@@ verif/tb.sv @@
// ============================================================================
// Soft-decision Viterbi decoder testbench
// Streams symbol pairs into the decoder under several polynomial and ceiling
// settings, predicts every decoded byte with an in-bench trellis, and checks
// the output stream beat by beat under random idling on both sides.
// ============================================================================
module tb;
	import svd_pkg::*;

	localparam int WIN      = DEF_WINDOW_DEPTH;
	localparam int TRC      = DEF_TRACE_DEPTH;
	localparam int MAX_OUT  = WIN / 8 + 1;
	localparam int SETTLE   = 600;     // Cycles for a flush or sweep to finish with no byte.
	localparam int IDLE_MAX = 20000;   // Watchdog limit on cycles with no beat at all.
	localparam int LONG_HOLD = 3000;

	typedef struct packed {
		logic signed [SOFT_W-1:0] sf;
		logic signed [SOFT_W-1:0] ss;
		logic                     eos;
		logic                     drain;   // Wait for every pending byte before offering.
	} symbol_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	soft_viterbi_decoder_k7_rate_half_unit uut (.*);

	always #6 clk = ~clk;

	// Model state of the decoder.
	logic [POLY_W-1:0]   gen_a, gen_b;
	logic [METRIC_W-1:0] ceiling;
	logic [METRIC_W-1:0] metric [NODES];
	logic                survivor [WIN][NODES];
	int                  held_layers;

	symbol_t sym_q[$];
	byte_t   byte_q[$];
	int      errors, n_sym, n_bytes, n_flush, n_cfg;

	function automatic int branch_cost(logic signed [7:0] s, logic one);
		if (s == -8'sd128)
			return 0;
		return one ? 128 - int'(s) : 128 + int'(s);
	endfunction

	function automatic int lowest_node();
		int best;
		best = 0;
		for (int n = 1; n < NODES; n++)
			if (metric[n] < metric[best])
				best = n;
		return best;
	endfunction

	// Walk back from a node, pass over the newest skip layers, then queue
	// the older layers as bytes, oldest byte first.
	task automatic trace_out(int node, int depth, int skip);
		logic [7:0] buf_b [MAX_OUT];
		int layer, nb;
		layer = depth - 1;
		if (skip > depth)
			return;
		nb = (depth - skip) / 8;
		for (int s = 0; s < skip; s++) begin
			if (layer >= 0)
				node = ((node << 1) & (NODES - 1)) | survivor[layer][node];
			layer--;
		end
		for (int b = nb; b > 0; b--) begin
			buf_b[b-1] = '0;
			for (int bit_i = 0; bit_i < 8; bit_i++) begin
				buf_b[b-1][bit_i] = node[NODE_W-1];
				if (layer >= 0)
					node = ((node << 1) & (NODES - 1)) | survivor[layer][node];
				layer--;
			end
		end
		for (int b = 0; b < nb; b++)
			byte_q.push_back('{data: buf_b[b], last: 1'b0});
	endtask

	// One accepted symbol: add-compare-select over all nodes, then the window
	// trace and the flush where they apply.
	task automatic decode_symbol(symbol_t sym);
		int bc [4];
		logic [METRIC_W-1:0] nxt [NODES];
		int prior_cnt, code, p0, c0, c1, pick, best, low;
		prior_cnt = byte_q.size();
		for (int c = 0; c < 4; c++)
			bc[c] = branch_cost(sym.sf, c[1]) + branch_cost(sym.ss, c[0]);
		if (held_layers >= WIN)
			held_layers = 0;
		for (int n = 0; n < NODES; n++) begin
			code = {^(n[6:0] & gen_a), ^(n[6:0] & gen_b)};
			p0 = (n << 1) & (NODES - 1);
			c0 = metric[p0] + bc[code];
			c1 = metric[p0 | 1] + bc[code];
			survivor[held_layers][n] = !(c0 < c1);
			pick = (c0 < c1) ? c0 : c1;
			nxt[n] = (pick > ceiling) ? ceiling : pick[METRIC_W-1:0];
		end
		metric = nxt;
		held_layers++;
		if (held_layers >= WIN) begin
			best = lowest_node();
			low = metric[best];
			trace_out(best, held_layers, TRC);
			for (int n = 0; n < NODES; n++)
				metric[n] = metric[n] - low;
			for (int l = 0; l < TRC; l++)
				survivor[l] = survivor[WIN - TRC + l];
			held_layers = TRC;
		end
		if (sym.eos) begin
			n_flush++;
			trace_out(lowest_node(), held_layers, held_layers % 8);
			held_layers = 0;
			for (int n = 0; n < NODES; n++)
				metric[n] = '0;
		end
		if (byte_q.size() > prior_cnt)
			byte_q[byte_q.size()-1].last = 1'b1;
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch on %s at byte %0d: got %0h, expected %0h", what, n_bytes, got, want);
		errors++;
	endtask

	// Sender: bursts of beats separated by random gaps.
	symbol_t cur;
	bit      nxt_valid;
	int      burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				decode_symbol(cur);
				n_sym++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (sym_q.size() > 0 && (!sym_q[0].drain || byte_q.size() == 0)) begin
					cur = sym_q.pop_front();
					s_tdata <= {cur.ss, cur.sf};
					s_tlast <= cur.eos;
					nxt_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
							: $urandom_range(0, 8);
					end
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	// Receiver and checker. The ready pattern switches between always ready,
	// coin flips and a fixed duty cycle; once, after a few bytes, it holds off
	// for a long stretch so the decoder backs up into its input.
	int  mode, mode_left, hold_left, cyc;
	bit  held_once, rdy;
	byte_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mode_left = 0;
			hold_left = 0;
			cyc = 0;
		end else begin
			cyc++;
			if (m_tvalid && m_tready) begin
				if (byte_q.size() == 0)
					report("unexpected beat", m_tdata, 0);
				else begin
					want = byte_q.pop_front();
					if (m_tdata !== want.data)
						report("data", m_tdata, want.data);
					if (m_tlast !== want.last)
						report("last flag", m_tlast, want.last);
				end
				n_bytes++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 400);
			end else
				mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!held_once && n_bytes >= 20) begin
				held_once = 1'b1;
				hold_left = LONG_HOLD;
				rdy = 1'b0;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					default: rdy = (cyc % 5) != 0;
				endcase
			end
			m_tready <= rdy;
		end
	end

	// Watchdog on cycles in which no channel moves a beat.
	int idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POLY_FIRST:     gen_a = value[POLY_W-1:0];
			REG_POLY_SECOND:    gen_b = value[POLY_W-1:0];
			REG_METRIC_CEILING: ceiling = value;
			default: ;
		endcase
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	task automatic push(int sf, int ss, bit eos, bit drain);
		sym_q.push_back('{sf: sf[7:0], ss: ss[7:0], eos: eos, drain: drain});
	endtask

	// Random streams, each closed by a flush; some run exactly one window so
	// that the window trace and the flush fall on the same symbol. The last
	// stream is cut short so the phase sends exactly its budget.
	task automatic add_streams(int budget);
		int len;
		while (budget > 0) begin
			case ($urandom_range(0, 5))
				0: len = WIN;
				1: len = WIN + $urandom_range(1, 70);
				default: len = $urandom_range(1, 40);
			endcase
			if (len > budget)
				len = budget;
			for (int i = 0; i < len; i++)
				push($urandom_range(0, 255), $urandom_range(0, 255), i == len - 1,
					$urandom_range(0, 39) == 0);
			budget -= len;
		end
	endtask

	task automatic settle();
		while (sym_q.size() > 0 || s_tvalid || byte_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		gen_a = POLY_FIRST_RST;
		gen_b = POLY_SECOND_RST;
		ceiling = CEILING_RST;
		held_layers = 0;
		for (int n = 0; n < NODES; n++)
			metric[n] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme soft values, a flush with no whole byte held, a flush
		// of one layer, and a flush that passes over a partial byte.
		push(-128, -128, 0, 0);
		push(127, 127, 0, 0);
		push(-128, 127, 1, 0);
		push(127, -128, 1, 0);
		for (int i = 0; i < 12; i++)
			push(i * 23 - 128, 127 - i * 19, i == 11, i == 0);
		push(0, 0, 0, 0);
		push(-1, 1, 0, 0);
		push(1, -1, 0, 1);
		push(-128, 0, 1, 0);
		settle();

		// Settings: defaults, all-zero extremes, all-one extremes, a tight
		// ceiling that saturates often, then random values.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_POLY_FIRST, 16'h4F); write_reg(REG_POLY_SECOND, 16'h6D);
					write_reg(REG_METRIC_CEILING, 16'hFFFF); end
				1: begin write_reg(REG_POLY_FIRST, 16'h0); write_reg(REG_POLY_SECOND, 16'h0);
					write_reg(REG_METRIC_CEILING, 16'h0); end
				2: begin write_reg(REG_POLY_FIRST, 16'h7F); write_reg(REG_POLY_SECOND, 16'h7F);
					write_reg(REG_METRIC_CEILING, 16'hFFFF); end
				3: begin write_reg(REG_POLY_FIRST, 16'h4F); write_reg(REG_POLY_SECOND, 16'h6D);
					write_reg(REG_METRIC_CEILING, 16'd300); end
				default: begin
					write_reg(REG_POLY_FIRST, $urandom_range(0, 127));
					write_reg(REG_POLY_SECOND, $urandom_range(0, 127));
					write_reg(REG_METRIC_CEILING, $urandom_range(0, 65535));
				end
			endcase
			push($urandom_range(0, 255), $urandom_range(0, 255), 0, 1);
			add_streams(ph == 0 ? 110 : 60);
			settle();
		end

		$display("Decoded %0d symbols into %0d bytes over %0d flushes and %0d register writes.",
			n_sym, n_bytes, n_flush, n_cfg);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
